/* sv/crast_pkg.sv */
// ----------------------------------------------------------------------------
// crast_pkg: shared types and constants of the circle rasterizer
// Job descriptor passed from the front end to the point generator.
// ----------------------------------------------------------------------------
package crast_pkg;

  localparam int COORD_W = 12;  // center coordinates, signed
  localparam int RAD_W   = 10;  // radius and stored octant offsets
  localparam int OFS_W   = 12;  // offsets as emitted, signed (-1 .. 1024)
  localparam int POS_W   = 14;  // center plus offset, signed
  localparam int D_W     = 16;  // decision term
  localparam int COLOR_W = 16;
  localparam int PX_W    = 8;
  localparam int PY_W    = 9;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [D_W-1:0] D_INIT     = 16'd3;
  localparam logic [D_W-1:0] D_STEP_IN  = 16'd6;
  localparam logic [D_W-1:0] D_STEP_OUT = 16'd10;

  // Job kinds: a single invisible result, four axis points, eight octant points
  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_AXIS = 2'd1,
    JOB_OCT  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t                  kind;
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [OFS_W-1:0]    a;    // x offset (0 on axis jobs)
    logic signed [OFS_W-1:0]    b;    // y offset (radius on axis jobs)
    logic [COLOR_W-1:0]         color;
    logic                       fin;
  } job_t;

  // Axis points reuse the octant sign/swap codes: (0,+r) (0,-r) (+r,0) (-r,0)
  function automatic logic [2:0] axis_code(input logic [1:0] k);
    logic [2:0] c;
    unique case (k)
      2'd0:    c = 3'd0;
      2'd1:    c = 3'd2;
      2'd2:    c = 3'd4;
      default: c = 3'd7;
    endcase
    return c;
  endfunction

endpackage

/* sv/crast_front.sv */
// ----------------------------------------------------------------------------
// crast_front: command decode and Bresenham state update
// Accepts start/step items, advances the decision term and queues one job.
// ----------------------------------------------------------------------------
module crast_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [55:0]         data,
  input  logic                q_full,
  output logic                push,
  output crast_pkg::job_t     job
);

  logic signed [crast_pkg::COORD_W-1:0] hold_cx, hold_cy;
  logic [crast_pkg::RAD_W-1:0]          step_offset, radial_offset;
  logic [crast_pkg::D_W-1:0]            decision_term;
  logic [crast_pkg::COLOR_W-1:0]        hold_color;
  logic                                 running;

  logic signed [crast_pkg::COORD_W-1:0] hold_cx_next, hold_cy_next;
  logic [crast_pkg::RAD_W-1:0]          step_offset_next, radial_offset_next;
  logic [crast_pkg::D_W-1:0]            decision_term_next;
  logic [crast_pkg::COLOR_W-1:0]        hold_color_next;
  logic                                 running_next;

  logic signed [crast_pkg::COORD_W-1:0] in_cx, in_cy;
  logic [crast_pkg::RAD_W-1:0]          in_r;
  logic [crast_pkg::COLOR_W-1:0]        in_color;
  logic signed [crast_pkg::OFS_W-1:0]   xn, yn;
  logic [crast_pkg::D_W-1:0]            x4, y4;

  assign in_cx    = data[11:0];
  assign in_cy    = data[23:12];
  assign in_r     = data[33:24];
  assign in_color = data[49:34];

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign x4 = crast_pkg::D_W'({step_offset, 2'b00});
  assign y4 = crast_pkg::D_W'({radial_offset, 2'b00});

  always_comb begin
    hold_cx_next       = hold_cx;
    hold_cy_next       = hold_cy;
    step_offset_next   = step_offset;
    radial_offset_next = radial_offset;
    decision_term_next = decision_term;
    hold_color_next    = hold_color;
    running_next       = running;
    xn                 = '0;
    yn                 = '0;
    job.kind           = crast_pkg::JOB_NONE;
    job.cx             = hold_cx;
    job.cy             = hold_cy;
    job.a              = '0;
    job.b              = '0;
    job.color          = hold_color;
    job.fin            = 1'b1;
    if (!func) begin
      // start: latch the circle, emit axis points unless the radius is zero
      hold_cx_next       = in_cx;
      hold_cy_next       = in_cy;
      radial_offset_next = in_r;
      hold_color_next    = in_color;
      step_offset_next   = '0;
      decision_term_next = crast_pkg::D_INIT - crast_pkg::D_W'({in_r, 1'b0});
      job.color          = in_color;
      job.cx             = in_cx;
      job.cy             = in_cy;
      if (in_r == '0) begin
        running_next = 1'b0;
      end else begin
        job.kind     = crast_pkg::JOB_AXIS;
        job.b        = crast_pkg::OFS_W'(in_r);
        job.fin      = (in_r == crast_pkg::RAD_W'(1));
        running_next = (in_r != crast_pkg::RAD_W'(1));
      end
    end else if (running) begin
      xn = crast_pkg::OFS_W'(step_offset) + crast_pkg::OFS_W'(1);
      if (decision_term[crast_pkg::D_W-1]) begin
        decision_term_next = decision_term + x4 + crast_pkg::D_STEP_IN;
        yn = crast_pkg::OFS_W'(radial_offset);
      end else begin
        decision_term_next = decision_term + x4 - y4 + crast_pkg::D_STEP_OUT;
        yn = crast_pkg::OFS_W'(radial_offset) - crast_pkg::OFS_W'(1);
      end
      step_offset_next   = xn[crast_pkg::RAD_W-1:0];
      radial_offset_next = yn[crast_pkg::RAD_W-1:0];
      running_next       = !(xn >= yn);
      job.kind           = crast_pkg::JOB_OCT;
      job.a              = xn;
      job.b              = yn;
      job.fin            = (xn >= yn);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cx       <= '0;
      hold_cy       <= '0;
      step_offset   <= '0;
      radial_offset <= '0;
      decision_term <= '0;
      hold_color    <= '0;
      running       <= 1'b0;
    end else if (push) begin
      hold_cx       <= hold_cx_next;
      hold_cy       <= hold_cy_next;
      step_offset   <= step_offset_next;
      radial_offset <= radial_offset_next;
      decision_term <= decision_term_next;
      hold_color    <= hold_color_next;
      running       <= running_next;
    end
  end

endmodule

/* sv/crast_queue.sv */
// ----------------------------------------------------------------------------
// crast_queue: short job FIFO between front end and point generator
// Head entry is read in place; it is popped when its last point is issued.
// ----------------------------------------------------------------------------
module crast_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crast_pkg::job_t  push_job,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output crast_pkg::job_t  head
);

  localparam int DEPTH = crast_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  crast_pkg::job_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/crast_back.sv */
// ----------------------------------------------------------------------------
// crast_back: point generator
// Walks the head job, one point per unstalled cycle; clips and registers each.
// ----------------------------------------------------------------------------
module crast_back #(
  parameter int SCREEN_W = 240,
  parameter int SCREEN_H = 320
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  crast_pkg::job_t  job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [39:0]      out_data,
  output logic [1:0]       out_user,
  output logic             out_last
);

  localparam logic signed [crast_pkg::POS_W-1:0] LIM_X = crast_pkg::POS_W'(SCREEN_W);
  localparam logic signed [crast_pkg::POS_W-1:0] LIM_Y = crast_pkg::POS_W'(SCREEN_H);

  logic [2:0]                          cnt;
  logic [2:0]                          last_idx;
  logic [2:0]                          code;
  logic                                issue, is_last, vis;
  logic signed [crast_pkg::OFS_W-1:0]  mag_x, mag_y;
  logic signed [crast_pkg::POS_W-1:0]  off_x, off_y, col, row;

  always_comb begin
    unique case (job.kind)
      crast_pkg::JOB_OCT:  last_idx = 3'd7;
      crast_pkg::JOB_AXIS: last_idx = 3'd3;
      default:             last_idx = 3'd0;
    endcase
  end

  assign code  = (job.kind == crast_pkg::JOB_AXIS) ? crast_pkg::axis_code(cnt[1:0]) : cnt;
  // code bit 2 swaps the offsets, bit 0 negates the column, bit 1 the row
  assign mag_x = code[2] ? job.b : job.a;
  assign mag_y = code[2] ? job.a : job.b;
  assign off_x = code[0] ? -crast_pkg::POS_W'(mag_x) : crast_pkg::POS_W'(mag_x);
  assign off_y = code[1] ? -crast_pkg::POS_W'(mag_y) : crast_pkg::POS_W'(mag_y);
  assign col   = crast_pkg::POS_W'(job.cx) + off_x;
  assign row   = crast_pkg::POS_W'(job.cy) + off_y;
  assign vis   = (job.kind != crast_pkg::JOB_NONE) &&
                 (col >= 0) && (col < LIM_X) && (row >= 0) && (row < LIM_Y);

  assign is_last = (cnt == last_idx);
  assign issue   = job_valid && (!out_valid || out_ready);
  assign pop     = issue && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        cnt <= is_last ? 3'd0 : cnt + 3'd1;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: pixel_x | pixel_y | pixel_color, flags visible | finished
  always_ff @(posedge clk) begin
    if (issue) begin
      out_data <= {7'd0, job.color,
                   vis ? row[crast_pkg::PY_W-1:0] : crast_pkg::PY_W'(0),
                   vis ? col[crast_pkg::PX_W-1:0] : crast_pkg::PX_W'(0)};
      out_user <= {is_last && job.fin, vis};
      out_last <= is_last;
    end
  end

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_user[0] |-> out_data[16:0] == '0)
    else $error("invisible point carries coordinates");

  a_mid_job_head: assert property (@(posedge clk) disable iff (rst)
    cnt != 3'd0 |-> job_valid)
    else $error("job left the queue before its last point");

  a_none_single: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.kind == crast_pkg::JOB_NONE |-> cnt == 3'd0)
    else $error("empty job walked past its single result");

  a_axis_four: assert property (@(posedge clk) disable iff (rst)
    job_valid && job.kind == crast_pkg::JOB_AXIS |-> cnt[2] == 1'b0)
    else $error("axis job walked past four points");

  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_user[1] |-> out_last)
    else $error("finished flag on a non-final result");

endmodule

/* sv/circle_rasterizer.sv */
// ----------------------------------------------------------------------------
// circle_rasterizer: midpoint (Bresenham) circle point generator
// Start items latch a circle and give the axis points, step items give the
// eight octant points of the next decision step, each clipped to the screen.
// ----------------------------------------------------------------------------
// Path: an accepted item enters the job queue, then its first result is
//   registered in the back end's output register before it shows on m_*.
// Throughput: one result per cycle unless m_tready stalls; 8 results per step,
//   4 per start and 1 per empty item; set by the single back-end generator.
// The two-entry job queue lets the front take the next item meanwhile.
// Reset (rst, synchronous): no circle active, queue empty, outputs idle.
module circle_rasterizer #(
  parameter int SCREEN_W = 240,
  parameter int SCREEN_H = 320
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // center_x[11:0], center_y[23:12], radius[33:24], pen_color[49:34], zero pad
  input  logic [55:0] s_tdata,
  // func[0]: 0 = start circle, 1 = step
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_x[7:0], pixel_y[16:8], pixel_color[32:17], zero pad
  output logic [39:0] m_tdata,
  // visible[0], finished[1]
  output logic [1:0]  m_tuser,
  // last_of_run
  output logic        m_tlast
);

  crast_pkg::job_t push_job, head_job;
  logic            push, pop, q_full, head_valid;

  // Front: decode, Bresenham update, one job per accepted item
  crast_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .func     (s_tuser[0]),
    .data     (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  // Job queue decouples item acceptance from point output
  crast_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head_job)
  );

  // Back: one clipped point per unstalled cycle into the output register
  crast_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

endmodule
